// File: rtl/tkst_pkg.sv
package tkst_pkg;

   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 5;
   localparam int MAX_ENTRIES_W = 5;
   localparam int MASK_W        = 4;
   localparam int RANK_OUT_W    = 4;
   localparam int COUNT_OUT_W   = 5;
   localparam int VALUE_W       = 32;

   localparam logic [MAX_ENTRIES_W-1:0] MAX_ENTRIES_RESET = 5'd16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_ENTRIES = 1'b0,
      CSR_LOWER_MASK  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]                 category;
      logic signed [VALUE_W-1:0]  score_value;
      logic [15:0]                payload_tag;
   } req_type;

   typedef struct packed {
      logic                       accepted;
      logic [RANK_OUT_W-1:0]      rank;
      logic signed [VALUE_W-1:0]  best_value;
      logic [COUNT_OUT_W-1:0]     entry_count;
   } rsp_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic                       write_en;
      logic                       lower_first;
      logic signed [VALUE_W-1:0]  new_value;
   } cell_ctrl_type;

endpackage

// File: rtl/tkst_cell.sv
module tkst_cell
   import tkst_pkg::*;
#(
   parameter int NUM_CATEGORIES = 4,
   parameter int TAG_WIDTH      = 16,
   parameter int CAT_W          = 2
) (
   input  logic                       clock,
   input  cell_ctrl_type              ctl,
   input  logic [CAT_W-1:0]           cat_idx,
   input  logic                       held,
   input  logic                       keep,
   input  logic                       found_in,
   input  logic signed [VALUE_W-1:0]  prev_value,
   input  logic [TAG_WIDTH-1:0]       prev_tag,
   input  logic [TAG_WIDTH-1:0]       new_tag,
   output logic                       found_out,
   output logic                       place,
   output logic signed [VALUE_W-1:0]  cur_value,
   output logic [TAG_WIDTH-1:0]       cur_tag
);

   logic signed [VALUE_W-1:0] value_ff [NUM_CATEGORIES];
   logic [TAG_WIDTH-1:0]      tag_ff   [NUM_CATEGORIES];
   logic signed [VALUE_W-1:0] value_in;
   logic [TAG_WIDTH-1:0]      tag_in;
   logic                      beats;
   logic                      hit;

   assign cur_value = value_ff[cat_idx];
   assign cur_tag   = tag_ff[cat_idx];

   always_comb begin
      beats = ctl.lower_first ? (ctl.new_value < cur_value) : (ctl.new_value > cur_value);
      // an empty slot is always a hit for the new entry; the first hit is its place
      hit       = !held || beats;
      place     = !found_in && hit;
      found_out = found_in || hit;
      if (place) begin
         value_in = ctl.new_value;
         tag_in   = new_tag;
      end else if (found_in) begin
         value_in = prev_value;
         tag_in   = prev_tag;
      end else begin
         value_in = cur_value;
         tag_in   = cur_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.write_en && keep) begin
         value_ff[cat_idx] <= value_in;
         tag_ff[cat_idx]   <= tag_in;
      end
   end

endmodule

// File: rtl/top_k_sorted_insert_table_core.sv
// channel   ports                         handshake
// -------   ---------------------------   ------------------------------------
// request   start, busy, req_data         taken when start && !busy
// result    rsp_valid, rsp_data           one-cycle strobe, cannot be stalled
// config    csr_we, csr_index, csr_wdata  written when csr_we, no wait
//
// A request is taken every cycle; busy stays low. The result of a request
// passes the request register, then the cell chain, where every cell compares
// and shifts, and is then registered in the response register on the way out.
// The rate is set by that single pass through the compare chain.
// Reset empties all lists at once and restores the config registers.
// The receiver cannot stall; results are never held back.
module top_k_sorted_insert_table_core
   import tkst_pkg::*;
#(
   parameter int NUM_CATEGORIES = 4,
   parameter int MAX_DEPTH      = 16,
   parameter int TAG_WIDTH      = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CAT_W  = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
   localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
   localparam int RANK_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   logic                     req_v_ff;
   req_type                  req_ff;
   logic [MAX_ENTRIES_W-1:0] max_ff;
   logic [MASK_W-1:0]        mask_ff;
   logic [CNT_W-1:0]         count_ff [NUM_CATEGORIES];
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;
   rsp_type                  rsp_in;

   logic                      cat_ok;
   logic [CAT_W-1:0]          cat_idx;
   logic [CNT_W-1:0]          count;
   logic [CNT_W-1:0]          limit;
   logic [CNT_W-1:0]          count_in;
   logic [CNT_W-1:0]          count_after;
   logic [MAX_DEPTH-1:0]      held;
   logic [MAX_DEPTH-1:0]      keep;
   logic [MAX_DEPTH-1:0]      in_limit;
   logic [MAX_DEPTH-1:0]      place;
   logic [MAX_DEPTH:0]        found;
   logic                      accept;
   logic [RANK_W-1:0]         rank_w;
   logic signed [VALUE_W-1:0] best;
   logic [TAG_WIDTH-1:0]      new_tag;
   cell_ctrl_type             ctl;

   logic signed [VALUE_W-1:0] cur_value [MAX_DEPTH];
   logic [TAG_WIDTH-1:0]      cur_tag   [MAX_DEPTH];

   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      cat_ok  = (32'(req_ff.category) < 32'(NUM_CATEGORIES));
      cat_idx = cat_ok ? CAT_W'(req_ff.category) : '0;
      count   = count_ff[cat_idx];
      if (32'(max_ff) > 32'(MAX_DEPTH)) begin
         limit = CNT_W'(MAX_DEPTH);
      end else begin
         limit = CNT_W'(max_ff);
      end
      count_in = (count < limit) ? CNT_W'(count + 1'b1) : limit;
      for (int k = 0; k < MAX_DEPTH; k++) begin
         held[k]     = CNT_W'(k) < count;
         keep[k]     = CNT_W'(k) < count_in;
         in_limit[k] = CNT_W'(k) < limit;
      end
      new_tag         = TAG_WIDTH'(req_ff.payload_tag);
      accept          = cat_ok && (|(place & in_limit));
      ctl.write_en    = req_v_ff && accept;
      ctl.lower_first = mask_ff[req_ff.category];
      ctl.new_value   = req_ff.score_value;
   end

   assign found[0] = 1'b0;

   for (genvar k = 0; k < MAX_DEPTH; k++) begin : g_cell
      tkst_cell #(
         .NUM_CATEGORIES (NUM_CATEGORIES),
         .TAG_WIDTH      (TAG_WIDTH),
         .CAT_W          (CAT_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cat_idx    (cat_idx),
         .held       (held[k]),
         .keep       (keep[k]),
         .found_in   (found[k]),
         .prev_value ((k == 0) ? req_ff.score_value : cur_value[(k == 0) ? 0 : k - 1]),
         .prev_tag   ((k == 0) ? new_tag : cur_tag[(k == 0) ? 0 : k - 1]),
         .new_tag    (new_tag),
         .found_out  (found[k+1]),
         .place      (place[k]),
         .cur_value  (cur_value[k]),
         .cur_tag    (cur_tag[k])
      );
   end

   always_comb begin
      rank_w = '0;
      for (int k = 0; k < MAX_DEPTH; k++) begin
         if (place[k]) begin
            rank_w = rank_w | RANK_W'(k);
         end
      end
      count_after = accept ? count_in : count;
      if (count_after == '0) begin
         best = '0;
      end else if (accept && place[0]) begin
         best = req_ff.score_value;
      end else begin
         best = cur_value[0];
      end
      rsp_in = '0;
      if (cat_ok) begin
         rsp_in.accepted    = accept;
         rsp_in.rank        = accept ? RANK_OUT_W'(rank_w) : '0;
         rsp_in.best_value  = best;
         rsp_in.entry_count = COUNT_OUT_W'(count_after);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_ff       <= MAX_ENTRIES_RESET;
         mask_ff      <= '0;
         for (int c = 0; c < NUM_CATEGORIES; c++) begin
            count_ff[c] <= '0;
         end
      end else begin
         req_v_ff     <= start && !busy;
         rsp_valid_ff <= req_v_ff;
         if (req_v_ff && accept) begin
            count_ff[cat_idx] <= count_in;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_ENTRIES: max_ff  <= MAX_ENTRIES_W'(csr_wdata);
               CSR_LOWER_MASK:  mask_ff <= MASK_W'(csr_wdata);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_valid)
      else $error("request did not produce a result two cycles later");

   a_single_place: assert property (@(posedge clock) disable iff (reset)
      req_v_ff |-> $onehot0(place))
      else $error("more than one cell claimed the insert position");

   a_rank_in_limit: assert property (@(posedge clock) disable iff (reset)
      req_v_ff && accept |-> CNT_W'(rank_w) < limit && count_in != '0)
      else $error("accepted request placed beyond the list limit");

   a_reject_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.accepted |-> rsp_data.rank == '0)
      else $error("rejected request reports a nonzero rank");
`endif

endmodule
